// ===== design/xcb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcb_pkg
// Shared types, constants and the character table of the base64 frame encoder.
// ----------------------------------------------------------------------------
package xcb_pkg;

  localparam int          FIFO_DEPTH_DEFAULT = 4;
  localparam logic [7:0]  TERMINATOR_RESET   = 8'd35;

  // One unit of work for the back end: three bytes to encode, and whether the
  // frame's terminator follows them.
  typedef struct packed {
    logic [23:0] word;
    logic        term;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CHARS,
    B_TERM
  } back_state_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'd97 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'd48 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

endpackage

// ===== design/xcb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcb_front
// Takes payload bytes, keeps the running checksum and gathers 3-byte groups
// into jobs for the back end.
// ----------------------------------------------------------------------------
module xcb_front
  import xcb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_in,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic [15:0] group_bytes, group_bytes_next;
  logic [1:0]  group_fill, group_fill_next;
  logic [7:0]  running_xor, running_xor_next;
  logic        pend, pend_next;
  logic [7:0]  pend_xor, pend_xor_next;
  logic [7:0]  xor_new;
  logic        take;

  assign in_ready = !pend && !q_full;
  assign take     = in_valid && in_ready;
  assign xor_new  = running_xor ^ data_byte;

  always_comb begin
    group_bytes_next = group_bytes;
    group_fill_next  = group_fill;
    running_xor_next = running_xor;
    pend_next        = pend;
    pend_xor_next    = pend_xor;
    q_push           = 1'b0;
    q_job            = '{word: {group_bytes, data_byte}, term: 1'b0};
    if (pend) begin
      // Second job of a last byte that closed a full group: checksum alone.
      if (!q_full) begin
        q_push    = 1'b1;
        q_job     = '{word: {pend_xor, 16'h0000}, term: 1'b1};
        pend_next = 1'b0;
      end
    end else if (take) begin
      if (!last_in) begin
        running_xor_next = xor_new;
        unique case (group_fill)
          2'd0: begin
            group_bytes_next = {data_byte, 8'h00};
            group_fill_next  = 2'd1;
          end
          2'd1: begin
            group_bytes_next = {group_bytes[15:8], data_byte};
            group_fill_next  = 2'd2;
          end
          default: begin
            q_push           = 1'b1;
            q_job            = '{word: {group_bytes, data_byte}, term: 1'b0};
            group_bytes_next = 16'h0000;
            group_fill_next  = 2'd0;
          end
        endcase
      end else begin
        q_push = 1'b1;
        unique case (group_fill)
          2'd0: q_job = '{word: {data_byte, xor_new, 8'h00}, term: 1'b1};
          2'd1: q_job = '{word: {group_bytes[15:8], data_byte, xor_new}, term: 1'b1};
          default: begin
            q_job         = '{word: {group_bytes, data_byte}, term: 1'b0};
            pend_next     = 1'b1;
            pend_xor_next = xor_new;
          end
        endcase
        group_bytes_next = 16'h0000;
        group_fill_next  = 2'd0;
        running_xor_next = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_bytes <= 16'h0000;
      group_fill  <= 2'd0;
      running_xor <= 8'h00;
      pend        <= 1'b0;
    end else begin
      group_bytes <= group_bytes_next;
      group_fill  <= group_fill_next;
      running_xor <= running_xor_next;
      pend        <= pend_next;
    end
    pend_xor <= pend_xor_next;
  end

endmodule

// ===== design/xcb_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcb_fifo
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module xcb_fifo
  import xcb_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/xcb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcb_back
// Turns queued jobs into base64 characters, one per cycle while the receiver
// takes them, followed by the terminator where the job asks for it.
// ----------------------------------------------------------------------------
module xcb_back
  import xcb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] terminator_char,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       last_out
);

  back_state_t state, state_next;
  logic [23:0] word;
  logic        term;
  logic [1:0]  idx, idx_next;
  logic [5:0]  sextet;
  logic        advance;
  logic        emit;
  logic [7:0]  emit_char;
  logic        emit_last;

  // The output register can take a new character when empty or being drained.
  assign advance = !out_valid || out_ready;

  always_comb begin
    unique case (idx)
      2'd0: sextet = word[23:18];
      2'd1: sextet = word[17:12];
      2'd2: sextet = word[11:6];
      default: sextet = word[5:0];
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (head_valid) begin
          state_next = B_CHARS;
        end
      end
      B_CHARS: begin
        if (advance && idx == 2'd3) begin
          if (term) begin
            state_next = B_TERM;
          end else if (!head_valid) begin
            state_next = B_IDLE;
          end
        end
      end
      B_TERM: begin
        if (advance) begin
          state_next = head_valid ? B_CHARS : B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    emit      = 1'b0;
    emit_char = b64_char(sextet);
    emit_last = 1'b0;
    idx_next  = idx;
    unique case (state)
      B_IDLE: begin
        pop = head_valid;
      end
      B_CHARS: begin
        if (advance) begin
          emit     = 1'b1;
          idx_next = idx + 2'd1;
          if (idx == 2'd3 && !term) begin
            pop = head_valid;
          end
        end
      end
      B_TERM: begin
        if (advance) begin
          emit      = 1'b1;
          emit_char = terminator_char;
          emit_last = 1'b1;
          pop       = head_valid;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= pop ? 2'd0 : idx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (pop) begin
      word <= head_job.word;
      term <= head_job.term;
    end
    if (emit) begin
      out_char <= emit_char;
      last_out <= emit_last;
    end
  end

endmodule

// ===== design/xor_checked_base64_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checked_base64_framer
// Base64 frame encoder with an appended XOR checksum byte and a terminator.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one payload byte per request, last_in on
// the final byte of a frame. Output channel (out_valid/out_ready): one
// character per request; last_out marks the terminator that closes a frame.
// Every three bytes give four characters; after the last byte the checksum
// byte is appended, a partial group is zero-filled, and the terminator follows.
// The terminator character is set through cfg_wr_en/cfg_wr_data while idle;
// the user must keep to this, the block does not enforce it. A group's first
// character passes the queue, the job word register and the output register
// after the byte that completes the group is taken. Throughput is bounded by
// the output, one character per cycle while the receiver takes them. The front
// end takes a byte every cycle while the job queue (FIFO_DEPTH entries) has
// room; a last byte that closes a full group needs two queue slots, and
// in_ready is low while the second is pushed. When the receiver stalls, the
// output register holds its character, the queue fills and in_ready falls.
// Reset clears the queue, the partial group and the checksum, and sets the
// terminator to '#'.
// ----------------------------------------------------------------------------
module xor_checked_base64_framer
  import xcb_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       last_out
);

  logic [7:0] terminator_char;
  logic       q_full, q_push, q_pop, head_valid;
  job_t       q_job, head_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      terminator_char <= TERMINATOR_RESET;
    end else if (cfg_wr_en) begin
      terminator_char <= cfg_wr_data;
    end
  end

  xcb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_in   (last_in),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  xcb_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  xcb_back u_back (
    .clk             (clk),
    .rst             (rst),
    .terminator_char (terminator_char),
    .head_valid      (head_valid),
    .head_job        (head_job),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .last_out        (last_out)
  );

endmodule

// ===== design/xcb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcb_checker
// Port-level checks of the frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
module xcb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       last_in,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       last_out
);

  logic [1:0] char_mod;
  logic       chars_seen;
  logic [7:0] frames_open;
  logic       out_take, frame_in, frame_out;

  assign out_take  = out_valid && out_ready;
  assign frame_in  = in_valid && in_ready && last_in;
  assign frame_out = out_take && last_out;

  // Base64 characters since the last terminator, and frames taken but not closed.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_mod    <= 2'd0;
      chars_seen  <= 1'b0;
      frames_open <= 8'd0;
    end else begin
      if (frame_out) begin
        char_mod   <= 2'd0;
        chars_seen <= 1'b0;
      end else if (out_take) begin
        char_mod   <= char_mod + 2'd1;
        chars_seen <= 1'b1;
      end
      frames_open <= frames_open + {7'd0, frame_in} - {7'd0, frame_out};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last_out))
    else $error("output request changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_whole_groups: assert property (@(posedge clk) disable iff (rst)
    frame_out |-> chars_seen && char_mod == 2'd0)
    else $error("terminator not preceded by whole groups of four characters");

  a_frame_known: assert property (@(posedge clk) disable iff (rst)
    frame_out |-> frames_open != 8'd0)
    else $error("terminator sent without a last byte taken");

endmodule

bind xor_checked_base64_framer xcb_checker u_xcb_checker (.*);

// ===== tb/xor_checked_base64_framer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checked_base64_framer_tb
// Sends frames of payload bytes into the base64 frame encoder. For each byte
// it works out the characters that the byte should produce: base64 groups,
// the XOR checksum group and the terminator. Every character that comes out
// is checked in order. Both sides idle at random, the receiver holds off once
// for a long stretch, and the terminator register is changed between frames.
// ----------------------------------------------------------------------------
module xor_checked_base64_framer_tb;
  import xcb_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 290;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } frame_char_t;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       last_in;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       last_out;

  // Predictor state.
  string       char_table = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  logic [15:0] grp_bytes;
  logic [1:0]  grp_fill;
  logic [7:0]  frame_xor;
  logic [7:0]  term_char;

  frame_char_t pending_chars[$];
  int          mismatch_count;
  int          quiet_cycles;
  int          items_sent;
  bit          tx_idle_on;
  bit          rx_idle_on;
  int          rx_hold_req;
  int          rx_stall_left;

  xor_checked_base64_framer u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .last_in     (last_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .last_out    (last_out)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(20, 60);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic void encode_group(input logic [23:0] word);
    frame_char_t c;
    for (int s = 18; s >= 0; s -= 6) begin
      c.ch   = char_table[(word >> s) & 24'h3F];
      c.last = 1'b0;
      pending_chars.push_back(c);
    end
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    if (grp_fill == 2'd0) begin
      grp_bytes = {b, 8'h00};
      grp_fill  = 2'd1;
    end else if (grp_fill == 2'd1) begin
      grp_bytes = {grp_bytes[15:8], b};
      grp_fill  = 2'd2;
    end else begin
      encode_group({grp_bytes, b});
      grp_bytes = '0;
      grp_fill  = 2'd0;
    end
  endfunction

  function automatic void predict_chars(input logic [7:0] b, input logic l);
    frame_char_t t;
    frame_xor = frame_xor ^ b;
    absorb_byte(b);
    if (l) begin
      absorb_byte(frame_xor);
      // A partial final group is zero-filled and still gives four characters.
      if (grp_fill != 2'd0) begin
        encode_group({grp_bytes, 8'h00});
      end
      t.ch   = term_char;
      t.last = 1'b1;
      pending_chars.push_back(t);
      grp_bytes = '0;
      grp_fill  = 2'd0;
      frame_xor = '0;
    end
  endfunction

  // Offers one byte; valid stays high from the previous request when no gap
  // is chosen.
  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    data_byte = b;
    last_in   = l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_chars(b, l);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_terminator(input logic [7:0] v);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    term_char = v;
  endtask

  task automatic send_frame(input int len);
    for (int k = 0; k < len; k++) begin
      send_byte(8'($urandom_range(0, 255)), k == len - 1);
    end
  endtask

  // Single-byte frames, partial and full final groups, and the characters
  // at both ends of the alphabet.
  task automatic test_directed_frames();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b1);
    wait_idle();
  endtask

  task automatic test_terminator_values();
    write_terminator(8'h00);
    send_frame(1);
    write_terminator(8'hFF);
    send_frame(2);
    write_terminator(8'($urandom_range(0, 255)));
    send_frame(3);
    write_terminator(TERMINATOR_RESET);
    send_frame(4);
    wait_idle();
  endtask

  // The receiver holds off while the sender keeps offering, so the job queue
  // fills and the input request is refused for a while.
  task automatic test_backpressure();
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    send_frame(29);
    wait_idle();
  endtask

  task automatic test_random_frames();
    int frames;
    int len;
    int phase;
    frames = 0;
    while (items_sent < RANDOM_ITEMS + 60) begin
      if (frames % 6 == 0) begin
        phase      = $urandom_range(0, 3);
        tx_idle_on = phase[0];
        rx_idle_on = phase[1];
      end
      if (frames % 7 == 6) begin
        write_terminator(8'($urandom_range(0, 255)));
      end
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      send_frame(len);
      frames++;
    end
    wait_idle();
  endtask

  // Receiver: random stalls, plus the long hold-off when one is asked for.
  initial begin
    out_ready     = 1'b0;
    rx_stall_left = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        rx_stall_left = rx_hold_req;
        rx_hold_req   = 0;
      end else if (rx_stall_left == 0 && rx_idle_on && $urandom_range(0, 4) == 0) begin
        rx_stall_left = pick_gap();
      end
      if (rx_stall_left > 0) begin
        out_ready = 1'b0;
        rx_stall_left--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    frame_char_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character %h last %b", $time, out_char, last_out);
        mismatch_count++;
      end else begin
        e = pending_chars.pop_front();
        if (out_char !== e.ch) begin
          $display("%0t: out_char expected %h actual %h", $time, e.ch, out_char);
          mismatch_count++;
        end
        if (last_out !== e.last) begin
          $display("%0t: last_out expected %b actual %b", $time, e.last, last_out);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 8'h00;
    in_valid       = 1'b0;
    data_byte      = 8'h00;
    last_in        = 1'b0;
    grp_bytes      = '0;
    grp_fill       = 2'd0;
    frame_xor      = '0;
    term_char      = TERMINATOR_RESET;
    mismatch_count = 0;
    items_sent     = 0;
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    rx_hold_req    = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_frames();
    test_terminator_values();
    test_backpressure();
    test_random_frames();

    wait_idle();
    if (pending_chars.size() != 0) begin
      $display("%0t: %0d characters never arrived", $time, pending_chars.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
